// ===== rtl/uhr_pkg.sv =====
// Shared types, constants and helper functions for the UDP hash-reply responder.
// No dependencies; every other file in rtl/ imports this package.

package uhr_pkg;

	localparam int HDR_BYTES    = 42;
	localparam int REPLY_BYTES  = 50;
	localparam int LEN_W        = 11;
	localparam int PORT_W       = 16;
	localparam int CK_W         = 20;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int RCNT_W       = $clog2(REPLY_BYTES);

	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

	localparam logic [7:0] ETH_IPV4_HI  = 8'h08;
	localparam logic [7:0] ETH_IPV4_LO  = 8'h00;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;
	localparam logic [7:0] IP_TOTAL_LEN = 8'd36;
	localparam logic [7:0] UDP_LEN      = 8'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_PORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_LEN    = 2'd2;

	localparam logic [PORT_W-1:0] LISTEN_PORT_RST = 16'd40000;
	localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST = 11'd100;
	localparam logic [LEN_W-1:0]  HASH_LEN_RST    = 11'd10;

	typedef enum logic [1:0] {
		VERDICT_PASS     = 2'd0,
		VERDICT_DROP     = 2'd1,
		VERDICT_TRANSMIT = 2'd2
	} verdict_t;

	typedef enum logic {
		BK_IDLE,
		BK_REPLY
	} back_state_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [7:0] reply_byte;
		logic       reply_valid;
		logic       result_last;
	} result_t;

	// One finished frame: its verdict and, for a reply, the whole reply in
	// wire order (byte 0 in the low lane).
	typedef struct packed {
		verdict_t                         verdict;
		logic [REPLY_BYTES-1:0][7:0]      reply;
	} job_t;

	// FNV-1a step; the prime 2^40 + 0x1B3 is applied as shifts and adds.
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

// ===== rtl/uhr_front.sv =====
// Front end: byte intake, header capture, FNV-1a hash, checksum and verdict.
// Depends on uhr_pkg; hands one job_t per frame to the job queue.

module uhr_front #(
	parameter int MAX_FRAME_BYTES = 2047
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  uhr_pkg::frame_t               frame,
	input  logic                          cfg_valid,
	input  logic [uhr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uhr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          q_full,
	output logic                          q_push,
	output uhr_pkg::job_t                 q_job
);
	import uhr_pkg::*;

	localparam int CW     = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LW     = (CW > LEN_W) ? CW : LEN_W;
	localparam int HIDX_W = $clog2(HDR_BYTES);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);

	logic [PORT_W-1:0] listen_q;
	logic [LEN_W-1:0]  plen_q;
	logic [LEN_W-1:0]  hlen_q;
	logic [CW-1:0]     count_q;
	logic [63:0]       hash_q;
	logic [CK_W-1:0]   ck_q;
	logic [7:0]        hdr_q [HDR_BYTES];

	logic              accept;
	logic              stored;
	logic              hash_en;
	logic              ck_en;
	logic              hdr_ok;
	logic [CW-1:0]     len;
	logic [LW-1:0]     pos_x;
	logic [63:0]       hash_nx;
	logic [63:0]       hash_fin;
	logic [15:0]       ck_term;
	logic [16:0]       fold1;
	logic [15:0]       fold2;
	logic [15:0]       csum;
	logic [7:0]        hv [HDR_BYTES];
	logic [REPLY_BYTES-1:0][7:0] rp;
	verdict_t          verdict;

	assign accept  = push & ~q_full;
	assign full    = q_full;
	assign stored  = count_q < MAX_CNT;
	assign pos_x   = LW'(count_q);
	assign hash_en = stored && (pos_x >= LW'(HDR_BYTES)) &&
		((pos_x - LW'(HDR_BYTES)) < LW'(hlen_q));
	assign len     = stored ? count_q + CW'(1) : count_q;
	assign hash_nx = fnv_step(hash_q, frame.frame_byte);
	assign hash_fin = hash_en ? hash_nx : hash_q;

	// Header view including the byte on the port this cycle.
	for (genvar k = 0; k < HDR_BYTES; k++) begin : g_hv
		assign hv[k] = (count_q == CW'(k)) ? frame.frame_byte : hdr_q[k];
	end

	// Checksum terms of the reply IP header; total length and checksum
	// fields take their reply values, address swap leaves the sum as is.
	assign ck_en = stored && (count_q >= CW'(14)) && (count_q <= CW'(33));
	always_comb begin
		if (count_q == CW'(16) || count_q == CW'(24) || count_q == CW'(25)) begin
			ck_term = 16'd0;
		end else if (count_q == CW'(17)) begin
			ck_term = {8'd0, IP_TOTAL_LEN};
		end else if (!count_q[0]) begin
			ck_term = {frame.frame_byte, 8'd0};
		end else begin
			ck_term = {8'd0, frame.frame_byte};
		end
	end

	assign fold1 = {1'b0, ck_q[15:0]} + 17'(ck_q[CK_W-1:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);
	assign csum  = ~fold2;

	assign hdr_ok = (len > CW'(14)) && (hv[12] == ETH_IPV4_HI) && (hv[13] == ETH_IPV4_LO) &&
		(len > CW'(34)) && (hv[23] == IP_PROTO_UDP) && (len >= CW'(HDR_BYTES)) &&
		({hv[36], hv[37]} == listen_q);

	always_comb begin
		if (!hdr_ok) begin
			verdict = VERDICT_PASS;
		end else if ((LW'(len) - LW'(HDR_BYTES)) == LW'(plen_q)) begin
			verdict = VERDICT_TRANSMIT;
		end else begin
			verdict = VERDICT_DROP;
		end
	end

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			rp[i]     = hv[6 + i];
			rp[6 + i] = hv[i];
		end
		for (int i = 12; i < 16; i++) begin
			rp[i] = hv[i];
		end
		rp[16] = 8'd0;
		rp[17] = IP_TOTAL_LEN;
		for (int i = 18; i < 24; i++) begin
			rp[i] = hv[i];
		end
		rp[24] = csum[15:8];
		rp[25] = csum[7:0];
		for (int i = 0; i < 4; i++) begin
			rp[26 + i] = hv[30 + i];
			rp[30 + i] = hv[26 + i];
		end
		rp[34] = hv[36];
		rp[35] = hv[37];
		rp[36] = hv[34];
		rp[37] = hv[35];
		rp[38] = 8'd0;
		rp[39] = UDP_LEN;
		rp[40] = 8'd0;
		rp[41] = 8'd0;
		for (int i = 0; i < 8; i++) begin
			rp[HDR_BYTES + i] = hash_fin[8 * i +: 8];
		end
	end

	assign q_push        = accept & frame.last_byte;
	assign q_job.verdict = verdict;
	assign q_job.reply   = rp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_q <= LISTEN_PORT_RST;
			plen_q   <= PAYLOAD_LEN_RST;
			hlen_q   <= HASH_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LISTEN_PORT: listen_q <= cfg_data;
				CFG_PAYLOAD_LEN: plen_q   <= cfg_data[LEN_W-1:0];
				CFG_HASH_LEN:    hlen_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hash_q  <= FNV_BASIS;
			ck_q    <= '0;
		end else if (accept) begin
			if (frame.last_byte) begin
				count_q <= '0;
				hash_q  <= FNV_BASIS;
				ck_q    <= '0;
			end else begin
				if (stored) begin
					count_q <= count_q + CW'(1);
				end
				if (hash_en) begin
					hash_q <= hash_nx;
				end
				if (ck_en) begin
					ck_q <= ck_q + CK_W'(ck_term);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && stored && (count_q < CW'(HDR_BYTES))) begin
			hdr_q[count_q[HIDX_W-1:0]] <= frame.frame_byte;
		end
	end

endmodule

// ===== rtl/uhr_queue.sv =====
// Short job queue between the front end and the reply serializer.
// Depends on uhr_pkg for job_t and the queue depth.

module uhr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  uhr_pkg::job_t wr_job,
	input  logic          pop,
	output logic          empty,
	output uhr_pkg::job_t head
);
	import uhr_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push;
	logic              do_pop;

	assign full    = fill_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty   = fill_q == '0;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + (QPTR_W + 1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W + 1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_job;
		end
	end

endmodule

// ===== rtl/uhr_back.sv =====
// Back end: takes jobs from the queue and shifts out result words.
// Depends on uhr_pkg; owns the output register seen on the result port.

module uhr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  uhr_pkg::job_t   q_head,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output uhr_pkg::result_t result
);
	import uhr_pkg::*;

	back_state_t                 state_q;
	back_state_t                 state_d;
	logic                        out_valid_q;
	result_t                     result_q;
	logic [REPLY_BYTES-1:0][7:0] sh_q;
	logic [RCNT_W-1:0]           cnt_q;
	logic                        adv;
	logic                        load;
	logic                        shift;

	assign adv    = ~out_valid_q | pop;
	assign empty  = ~out_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		load    = 1'b0;
		shift   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && adv) begin
					q_pop = 1'b1;
					load  = 1'b1;
					if (q_head.verdict == VERDICT_TRANSMIT) begin
						state_d = BK_REPLY;
					end
				end
			end
			BK_REPLY: begin
				if (adv) begin
					shift = 1'b1;
					if (cnt_q == RCNT_W'(1)) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			cnt_q       <= RCNT_W'(REPLY_BYTES - 1);
		end else if (shift) begin
			out_valid_q <= 1'b1;
			cnt_q       <= cnt_q - RCNT_W'(1);
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.verdict <= q_head.verdict;
			sh_q             <= {8'h00, q_head.reply[REPLY_BYTES-1:1]};
			if (q_head.verdict == VERDICT_TRANSMIT) begin
				result_q.reply_byte  <= q_head.reply[0];
				result_q.reply_valid <= 1'b1;
				result_q.result_last <= 1'b0;
			end else begin
				result_q.reply_byte  <= 8'd0;
				result_q.reply_valid <= 1'b0;
				result_q.result_last <= 1'b1;
			end
		end else if (shift) begin
			result_q.verdict     <= VERDICT_TRANSMIT;
			result_q.reply_byte  <= sh_q[0];
			result_q.reply_valid <= 1'b1;
			result_q.result_last <= cnt_q == RCNT_W'(1);
			sh_q                 <= {8'h00, sh_q[REPLY_BYTES-1:1]};
		end
	end

endmodule

// ===== rtl/udp_hash_reply_responder_top.sv =====
// Top level of the UDP hash-reply responder: front end, job queue, back end.
// Depends on uhr_pkg, uhr_front, uhr_queue and uhr_back.
//
//   channel   handshake            payload            meaning
//   --------  -------------------  -----------------  ------------------------------
//   frame     push / full          frame_t            one received frame byte + last
//   result    pop / empty          result_t           verdict or one reply byte
//   config    cfg_valid/cfg_ready  cfg_index/cfg_data listen port, lengths
//
// Frame bytes are taken one per cycle while full is low; the verdict is settled
// on the cycle the last byte is taken and queued as one job (up to two jobs wait).
// Each job drains as one result word (pass, drop) or 50 reply words, one
// per cycle while pop is held; that serializer bounds the frame rate.
// full rises only while the job queue holds two jobs. Reset clears counters,
// hash, queue pointers and output valid flag at once; there is no clearing pass.

module udp_hash_reply_responder_top #(
	parameter int MAX_FRAME_BYTES = 2047
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  uhr_pkg::frame_t                frame,
	output logic                           empty,
	input  logic                           pop,
	output uhr_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [uhr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uhr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import uhr_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_wr_job;
	job_t q_head;

	// Register writes are never stalled; cfg_ready is tied high.
	assign cfg_ready = 1'b1;

	// Capture header, hash payload, decide the verdict.
	uhr_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.frame    (frame),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_wr_job)
	);

	// Hold finished frames so parsing of the next frame goes on.
	uhr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.full  (q_full),
		.wr_job(q_wr_job),
		.pop   (q_pop),
		.empty (q_empty),
		.head  (q_head)
	);

	// Drain jobs word by word into the result register.
	uhr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_head (q_head),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// ===== tb/sv/udp_hash_reply_responder_top_test.sv =====
// Self-checking testbench for udp_hash_reply_responder_top: a directed table of frames and
// register writes, then random frames under three idling patterns. Depends on uhr_pkg and the RTL.

module udp_hash_reply_responder_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import uhr_pkg::*;

	// Reply rules as the responder defines them; kept here apart from the RTL.
	localparam int          FRAME_CAP     = 2047;
	localparam logic [63:0] FNV_PRIME     = 64'h0000_0100_0000_01B3;
	localparam logic [15:0] PORT_AT_RESET = 16'd40000;
	localparam logic [10:0] PLEN_AT_RESET = 11'd100;
	localparam logic [10:0] HLEN_AT_RESET = 11'd10;
	localparam int          QUIET_LIMIT   = 3000;  // cycles with no word moved on any channel
	localparam int          DRAIN_PAUSE   = 8;     // hold before a register write
	localparam int          END_PAUSE     = 64;    // catch stray words once nothing is expected
	localparam int          PHASE_BYTES   = 48;    // random bytes per idling pattern
	localparam int          PLAN_ROWS     = 11;
	localparam int          PRINT_CAP     = 100;

	// How a frame is shaped, or which register a table row writes.
	typedef enum logic [2:0] {
		ROW_GOOD,       // IPv4/UDP header aimed at the listen port
		ROW_NOISE,      // every byte random
		ROW_BAD_ETH,    // ethertype other than IPv4
		ROW_BAD_PROTO,  // IP protocol other than UDP
		ROW_BAD_PORT,   // destination port other than the listen port
		ROW_SET_PORT,
		ROW_SET_PLEN,
		ROW_SET_HLEN
	} row_kind_t;

	// Where the expected words of a frame come from.
	typedef enum logic [1:0] {
		OUT_PREDICT,
		OUT_PASS,
		OUT_DROP
	} outcome_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [15:0] val;      // frame length in bytes, or register data
		outcome_t    outcome;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	frame_t      frame = '0;
	logic        empty;
	logic        pop = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: header bytes, length so far, running hash, register copies.
	logic [7:0]  hdr_copy [HDR_BYTES];
	logic [10:0] seen_count = '0;
	logic [63:0] fnv_acc = FNV_BASIS;
	logic [15:0] port_cfg = PORT_AT_RESET;
	logic [10:0] plen_cfg = PLEN_AT_RESET;
	logic [10:0] hlen_cfg = HLEN_AT_RESET;

	result_t  expected_words [$];  // words the responder owes, oldest first
	outcome_t verdict_notes [$];   // one per frame on its way in
	row_t     plan [PLAN_ROWS];

	int send_gap_pct = 19;
	int recv_stall_pct = 87;
	int fail_count = 0;
	int quiet_cycles = 0;

	udp_hash_reply_responder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.frame     (frame),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic result_t reply_word(input verdict_t v, input logic [7:0] b,
			input logic vld, input logic lst);
		result_t w;
		w.verdict = v;
		w.reply_byte = b;
		w.reply_valid = vld;
		w.result_last = lst;
		return w;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
	endtask

	// Advance the predictor by one accepted frame byte; on the last byte queue the words
	// the frame owes: one verdict word, or the 50-byte reply.
	task automatic predict_frame_byte(input logic [7:0] b, input logic fin);
		logic [10:0] flen;
		logic [63:0] digest;
		verdict_t    v;
		outcome_t    note;
		logic [7:0]  r [REPLY_BYTES];
		logic [31:0] sum;
		int          i;
		// Past the cap, bytes are neither stored nor hashed and the length stays put.
		if (seen_count < FRAME_CAP) begin
			if (seen_count < HDR_BYTES) begin
				hdr_copy[seen_count] = b;
			end else if (seen_count - HDR_BYTES < hlen_cfg) begin
				fnv_acc = (fnv_acc ^ {56'd0, b}) * FNV_PRIME;
			end
			seen_count = seen_count + 11'd1;
		end
		if (!fin)
			return;
		flen = seen_count;
		digest = fnv_acc;
		seen_count = '0;
		fnv_acc = FNV_BASIS;
		note = (verdict_notes.size() != 0) ? verdict_notes.pop_front() : OUT_PREDICT;
		if (note == OUT_PASS) begin
			expected_words.push_back(reply_word(VERDICT_PASS, 8'h00, 1'b0, 1'b1));
			return;
		end
		if (note == OUT_DROP) begin
			expected_words.push_back(reply_word(VERDICT_DROP, 8'h00, 1'b0, 1'b1));
			return;
		end
		// Length checks come first so that no header byte of an older frame is read.
		v = VERDICT_PASS;
		if (flen > 14 && hdr_copy[12] == ETH_IPV4_HI && hdr_copy[13] == ETH_IPV4_LO &&
				flen > 34 && hdr_copy[23] == IP_PROTO_UDP && flen >= HDR_BYTES &&
				{hdr_copy[36], hdr_copy[37]} == port_cfg)
			v = (flen - HDR_BYTES == plen_cfg) ? VERDICT_TRANSMIT : VERDICT_DROP;
		if (v != VERDICT_TRANSMIT) begin
			expected_words.push_back(reply_word(v, 8'h00, 1'b0, 1'b1));
			return;
		end
		// Swap MACs, IPs and ports; fix both lengths; zero the UDP checksum.
		for (i = 0; i < HDR_BYTES; i++)
			r[i] = hdr_copy[i];
		for (i = 0; i < 6; i++) begin
			r[i] = hdr_copy[i + 6];
			r[i + 6] = hdr_copy[i];
		end
		for (i = 0; i < 4; i++) begin
			r[26 + i] = hdr_copy[30 + i];
			r[30 + i] = hdr_copy[26 + i];
		end
		r[16] = 8'h00;
		r[17] = IP_TOTAL_LEN;
		r[24] = 8'h00;
		r[25] = 8'h00;
		r[34] = hdr_copy[36];
		r[35] = hdr_copy[37];
		r[36] = hdr_copy[34];
		r[37] = hdr_copy[35];
		r[38] = 8'h00;
		r[39] = UDP_LEN;
		r[40] = 8'h00;
		r[41] = 8'h00;
		// IP header checksum over 20 bytes, carries folded until none is left.
		sum = '0;
		for (i = 0; i < 10; i++)
			sum = sum + {16'd0, r[14 + 2 * i], r[15 + 2 * i]};
		while (sum > 32'h0000_FFFF)
			sum = {16'd0, sum[15:0]} + (sum >> 16);
		sum = ~sum;
		r[24] = sum[15:8];
		r[25] = sum[7:0];
		// Hash goes out least significant byte first.
		for (i = 0; i < 8; i++)
			r[HDR_BYTES + i] = digest[8 * i +: 8];
		for (i = 0; i < REPLY_BYTES; i++)
			expected_words.push_back(reply_word(VERDICT_TRANSMIT, r[i], 1'b1,
				i == REPLY_BYTES - 1));
	endtask

	task automatic check_word(input result_t got);
		result_t want;
		if (expected_words.size() == 0) begin
			note_mismatch("word with nothing expected", '0, got);
			return;
		end
		want = expected_words.pop_front();
		if (got.verdict !== want.verdict)
			note_mismatch("verdict", want.verdict, got.verdict);
		if (got.reply_byte !== want.reply_byte)
			note_mismatch("reply_byte", want.reply_byte, got.reply_byte);
		if (got.reply_valid !== want.reply_valid)
			note_mismatch("reply_valid", want.reply_valid, got.reply_valid);
		if (got.result_last !== want.result_last)
			note_mismatch("result_last", want.result_last, got.result_last);
	endtask

	// Monitor: sample every channel at the edge, check result words, feed the predictor,
	// and end the run if no word moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_word(result);
			if (push && !full)
				predict_frame_byte(frame.frame_byte, frame.last_byte);
			if ((pop && !empty) || (push && !full) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	// Receiver: stall pop at random, at the rate the current pattern sets.
	always @(posedge clk)
		pop <= arst_n && ($urandom_range(99) >= recv_stall_pct);

	// Offer one frame byte, idling first at random; return at the edge that takes it.
	// push stays high so the next byte can follow on the very next cycle.
	task automatic put_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		frame <= '{frame_byte: b, last_byte: fin};
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Build a frame of the given shape around the current listen port and send it.
	task automatic send_frame(input row_kind_t kind, input int flen, input outcome_t oc);
		logic [7:0]  hb [HDR_BYTES];
		logic [15:0] port;
		int          i;
		for (i = 0; i < HDR_BYTES; i++)
			hb[i] = 8'($urandom);
		if (kind != ROW_NOISE) begin
			hb[12] = ETH_IPV4_HI;
			hb[13] = ETH_IPV4_LO;
			hb[23] = IP_PROTO_UDP;
			port = port_cfg;
			case (kind)
				ROW_BAD_ETH: begin
					if ($urandom_range(1) == 0)
						hb[12] = ETH_IPV4_HI ^ 8'($urandom_range(1, 255));
					else
						hb[13] = ETH_IPV4_LO ^ 8'($urandom_range(1, 255));
				end
				ROW_BAD_PROTO: hb[23] = IP_PROTO_UDP ^ 8'($urandom_range(1, 255));
				ROW_BAD_PORT: port = port ^ 16'($urandom_range(1, 65535));
				default: ;
			endcase
			{hb[36], hb[37]} = port;
		end
		verdict_notes.push_back(oc);
		for (i = 0; i < flen; i++)
			put_byte((i < HDR_BYTES) ? hb[i] : 8'($urandom), i == flen - 1);
	endtask

	// Drop push, then hold until every frame has been taken and every word delivered.
	task automatic wait_quiet();
		push <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0 || verdict_notes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// Write one register; keep valid high when another write follows at once.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data,
			input logic more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (!more)
			cfg_valid <= 1'b0;
		case (idx)
			CFG_LISTEN_PORT: port_cfg = data;
			CFG_PAYLOAD_LEN: plen_cfg = data[10:0];
			CFG_HASH_LEN:    hlen_cfg = data[10:0];
			default: ;
		endcase
	endtask

	initial begin
		int                   n;
		int                   phase;
		int                   sent;
		int                   flen;
		int                   pick;
		row_t                 cur;
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;

		// Directed rows. Verdicts that follow straight from the length or a broken field
		// are written in; every reply comes from the predictor.
		plan = '{
			'{ROW_GOOD,      16'd43,    OUT_DROP},     // reset port and length: one-byte payload
			'{ROW_NOISE,     16'd1,     OUT_PASS},     // single-byte frame
			'{ROW_GOOD,      16'd14,    OUT_PASS},     // no room for an ethertype check
			'{ROW_SET_PORT,  16'd0,     OUT_PREDICT},
			'{ROW_SET_PLEN,  16'd0,     OUT_PREDICT},
			'{ROW_SET_HLEN,  16'd0,     OUT_PREDICT},
			'{ROW_GOOD,      16'd42,    OUT_PREDICT},  // empty payload, hash left at basis
			'{ROW_SET_PORT,  16'd65535, OUT_PREDICT},
			'{ROW_SET_PLEN,  16'd1472,  OUT_PREDICT},
			'{ROW_SET_HLEN,  16'd1472,  OUT_PREDICT},
			'{ROW_GOOD,      16'd43,    OUT_DROP}      // payload far short of the largest length
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the table; drain before each run of register writes.
		for (n = 0; n < PLAN_ROWS; n++) begin
			cur = plan[n];
			if (cur.kind >= ROW_SET_PORT) begin
				if (n == 0 || plan[n - 1].kind < ROW_SET_PORT)
					wait_quiet();
				case (cur.kind)
					ROW_SET_PORT: idx = CFG_LISTEN_PORT;
					ROW_SET_PLEN: idx = CFG_PAYLOAD_LEN;
					default:      idx = CFG_HASH_LEN;
				endcase
				write_reg(idx, cur.val, n + 1 < PLAN_ROWS && plan[n + 1].kind >= ROW_SET_PORT);
			end else begin
				send_frame(cur.kind, cur.val, cur.outcome);
			end
		end

		// Random part: one setting per idling pattern, short payloads so that most frames
		// get all the way to a reply; the rest are cut, broken or plain noise.
		for (phase = 0; phase < 3; phase++) begin
			wait_quiet();
			case (phase)
				0: begin
					send_gap_pct = 19;
					recv_stall_pct = 87;
				end
				1: begin
					send_gap_pct = 87;
					recv_stall_pct = 19;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			write_reg(CFG_LISTEN_PORT, 16'($urandom_range(0, 65535)), 1'b1);
			write_reg(CFG_PAYLOAD_LEN, 16'($urandom_range(0, 6)), 1'b1);
			write_reg(CFG_HASH_LEN, ($urandom_range(3) == 0) ? 16'd1472 :
				16'($urandom_range(0, 8)), 1'b0);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				pick = $urandom_range(99);
				kind = ROW_GOOD;
				flen = HDR_BYTES + plen_cfg;
				if (pick >= 55 && pick < 65) begin
					// wrong payload length
					if (plen_cfg != 0 && $urandom_range(1) == 0)
						flen = flen - $urandom_range(1, plen_cfg);
					else
						flen = flen + $urandom_range(1, 3);
				end else if (pick >= 65 && pick < 72) begin
					flen = $urandom_range(1, HDR_BYTES - 1);
				end else if (pick >= 72 && pick < 80) begin
					kind = ROW_NOISE;
					flen = $urandom_range(1, 60);
				end else if (pick >= 80 && pick < 87) begin
					kind = ROW_BAD_ETH;
				end else if (pick >= 87 && pick < 94) begin
					kind = ROW_BAD_PROTO;
				end else if (pick >= 94) begin
					kind = ROW_BAD_PORT;
				end
				send_frame(kind, flen, OUT_PREDICT);
				sent += flen;
			end
		end

		// Drain, then watch a while longer for words nobody asked for.
		wait_quiet();
		repeat (END_PAUSE) @(posedge clk);
		if (expected_words.size() != 0)
			note_mismatch("words never delivered", expected_words.size(), 0);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
